// File: design/cfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the clipmap footprint placer modules.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam int MAX_LEVELS = 5;
    localparam int FRAC_BITS  = 8;

    localparam logic [2:0] REG_CELL_X  = 3'd0;
    localparam logic [2:0] REG_CELL_Y  = 3'd1;
    localparam logic [2:0] REG_SHIFT_X = 3'd2;
    localparam logic [2:0] REG_SHIFT_Y = 3'd3;
    localparam logic [2:0] REG_EXP     = 3'd4;
    localparam logic [2:0] REG_LEVELS  = 3'd5;

    typedef struct packed {
        logic signed [31:0] focus_x;
        logic signed [31:0] focus_y;
        logic [30:0]        view_distance;
    } in_item_t;

    typedef struct packed {
        logic               piece_kind;
        logic [2:0]         level_index;
        logic [3:0]         block_slot;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic [39:0]        width_x;
        logic [39:0]        width_y;
        logic [5:0]         block_count;
        logic               last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input item, start level 0
        logic       lvl_setup; // compute scaled cell sizes for current level
        logic       mod_start; // start floor modulo for both axes
        logic       snap;      // form snapped centres
        logic       cache_wr;  // write snapped centre into cache
        logic       ring_emit; // load output with ring block
        logic       int_emit;  // load output with interior block
        logic       next_lvl;
        logic [3:0] slot;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic stop;      // this level is the final one
        logic same;      // snapped centre matches cache
        logic mod_done;
    } status_t;

    function automatic logic signed [1:0] lvl_off_x(input logic [3:0] i);
        case (i)
            4'd0, 4'd1, 4'd4, 4'd6, 4'd8, 4'd9: lvl_off_x = -2'sd1;
            default:                             lvl_off_x = 2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] lvl_off_y(input logic [3:0] i);
        lvl_off_y = (i < 4'd6) ? 2'sd1 : -2'sd1;
    endfunction

    function automatic logic signed [2:0] blk_off_x(input logic [3:0] i);
        case (i)
            4'd0, 4'd4, 4'd6, 4'd8: blk_off_x = 3'sd1;
            4'd1, 4'd9:             blk_off_x = 3'sd3;
            4'd2, 4'd10:            blk_off_x = -3'sd3;
            default:                blk_off_x = -3'sd1;
        endcase
    endfunction

    function automatic logic signed [2:0] blk_off_y(input logic [3:0] i);
        case (i)
            4'd0, 4'd1, 4'd2, 4'd3: blk_off_y = -3'sd1;
            4'd4, 4'd5:             blk_off_y = -3'sd3;
            4'd6, 4'd7:             blk_off_y = 3'sd3;
            default:                blk_off_y = 3'sd1;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647)       sat32 = 32'sh7fffffff;
        else if (v < -44'sd2147483648) sat32 = 32'sh80000000;
        else                           sat32 = v[31:0];
    endfunction

endpackage
`default_nettype wire

// File: design/cfp_floor_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_floor_mod
// Bit-serial floor modulo of a signed 32-bit value by a positive 21-bit
// divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cfp_floor_mod (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] dividend,
    input  wire logic [20:0]        divisor,
    output logic [20:0]             rem,
    output logic                    done
);
    logic [31:0] num_reg;
    logic [21:0] acc_reg;
    logic [20:0] div_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [21:0] trial;
    logic [21:0] mag_rem;

    assign trial   = {acc_reg[20:0], num_reg[31]} - {1'b0, div_reg};
    assign mag_rem = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[31];
            num_reg <= dividend[31] ? (32'd0 - dividend) : dividend;
            div_reg <= divisor;
            acc_reg <= 22'd0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[30:0], 1'b0};
            if (!trial[21])
                acc_reg <= trial;
            else
                acc_reg <= {acc_reg[20:0], num_reg[31]};
        end
    end

    assign done = !busy_reg;
    // magnitude remainder -> floor remainder
    assign rem  = (neg_reg && mag_rem != 22'd0) ? (div_reg - mag_rem[20:0])
                                                : mag_rem[20:0];
endmodule
`default_nettype wire

// File: design/cfp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_datapath
// Configuration registers, level geometry, snap, cache and result register.
// ----------------------------------------------------------------------------
module cfp_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data,
    input  wire cfp_pkg::in_item_t in_item,
    input  wire cfp_pkg::cmd_t     cmd,
    output cfp_pkg::status_t       status,
    output cfp_pkg::out_item_t     out_item
);
    logic [15:0]        cell_x_reg, cell_y_reg;
    logic signed [31:0] shift_x_reg, shift_y_reg;
    logic [3:0]         exp_reg;
    logic [2:0]         lvls_reg;

    cfp_pkg::in_item_t  item_reg;
    logic [2:0]         lvl_reg;
    logic [2:0]         nlev_reg;
    logic [3:0]         k_reg;
    logic [20:0]        sx_reg, sy_reg;
    logic [39:0]        lwx_reg, lwy_reg, bwx_reg, bwy_reg;
    logic signed [43:0] gx_reg, gy_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic signed [31:0] cache_x_reg [cfp_pkg::MAX_LEVELS];
    logic signed [31:0] cache_y_reg [cfp_pkg::MAX_LEVELS];
    cfp_pkg::out_item_t out_reg;

    logic [20:0] rem_x, rem_y;
    logic        done_x, done_y;
    logic [2:0]  sh;
    logic [12:0] lcells, bcells;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_x_reg  <= 16'd256;
            cell_y_reg  <= 16'd256;
            shift_x_reg <= 32'sd0;
            shift_y_reg <= 32'sd0;
            exp_reg     <= 4'd7;
            lvls_reg    <= 3'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfp_pkg::REG_CELL_X:  cell_x_reg  <= cfg_data[15:0];
                cfp_pkg::REG_CELL_Y:  cell_y_reg  <= cfg_data[15:0];
                cfp_pkg::REG_SHIFT_X: shift_x_reg <= cfg_data;
                cfp_pkg::REG_SHIFT_Y: shift_y_reg <= cfg_data;
                cfp_pkg::REG_EXP:     exp_reg     <= cfg_data[3:0];
                cfp_pkg::REG_LEVELS:  lvls_reg    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cfp_pkg::MAX_LEVELS; i++)
            begin
                cache_x_reg[i] <= 32'sd0;
                cache_y_reg[i] <= 32'sd0;
            end
        end
        else if (cmd.cache_wr)
        begin
            cache_x_reg[lvl_reg] <= cx_reg;
            cache_y_reg[lvl_reg] <= cy_reg;
        end
    end

    assign sh     = nlev_reg - lvl_reg - 3'd1;
    assign lcells = (13'd1 << k_reg) - 13'd2;
    assign bcells = (13'd1 << (k_reg - 4'd2)) - 13'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            lvl_reg  <= 3'd0;
            k_reg    <= (exp_reg < 4'd3) ? 4'd3 : ((exp_reg > 4'd12) ? 4'd12 : exp_reg);
            nlev_reg <= (lvls_reg == 3'd0) ? 3'd1
                      : ((lvls_reg > 3'(cfp_pkg::MAX_LEVELS)) ? 3'(cfp_pkg::MAX_LEVELS)
                                                             : lvls_reg);
        end
        else if (cmd.next_lvl)
            lvl_reg <= lvl_reg + 3'd1;
        if (cmd.lvl_setup)
        begin
            sx_reg <= {5'd0, (cell_x_reg == 16'd0) ? 16'd1 : cell_x_reg} << sh;
            sy_reg <= {5'd0, (cell_y_reg == 16'd0) ? 16'd1 : cell_y_reg} << sh;
        end
        if (cmd.mod_start)
        begin
            lwx_reg <= 40'(sx_reg * lcells);
            lwy_reg <= 40'(sy_reg * lcells);
            bwx_reg <= 40'(sx_reg * bcells);
            bwy_reg <= 40'(sy_reg * bcells);
        end
        if (cmd.snap)
        begin
            gx_reg <= 44'(item_reg.focus_x) - 44'(rem_x) + 44'(sx_reg) + 44'(shift_x_reg);
            gy_reg <= 44'(item_reg.focus_y) - 44'(rem_y) + 44'(sy_reg) + 44'(shift_y_reg);
            cx_reg <= cfp_pkg::sat32(44'(item_reg.focus_x) - 44'(rem_x) + 44'(sx_reg)
                                     + 44'(shift_x_reg));
            cy_reg <= cfp_pkg::sat32(44'(item_reg.focus_y) - 44'(rem_y) + 44'(sy_reg)
                                     + 44'(shift_y_reg));
        end
    end

    cfp_floor_mod u_mod_x (
        .clk(clk), .rst_n(rst_n), .start(cmd.mod_start),
        .dividend(item_reg.focus_x), .divisor({sx_reg[19:0], 1'b0}),
        .rem(rem_x), .done(done_x)
    );
    cfp_floor_mod u_mod_y (
        .clk(clk), .rst_n(rst_n), .start(cmd.mod_start),
        .dividend(item_reg.focus_y), .divisor({sy_reg[19:0], 1'b0}),
        .rem(rem_y), .done(done_y)
    );

    // ring centre: (2g + lo*lw + bo*bw) >> 1, floor
    logic signed [45:0] dx, dy;
    always_comb
    begin
        dx = 46'(gx_reg) * 46'sd2
           + 46'(cfp_pkg::lvl_off_x(cmd.slot)) * $signed({6'd0, lwx_reg})
           + 46'(cfp_pkg::blk_off_x(cmd.slot)) * $signed({6'd0, bwx_reg});
        dy = 46'(gy_reg) * 46'sd2
           + 46'(cfp_pkg::lvl_off_y(cmd.slot)) * $signed({6'd0, lwy_reg})
           + 46'(cfp_pkg::blk_off_y(cmd.slot)) * $signed({6'd0, bwy_reg});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ring_emit)
        begin
            out_reg.piece_kind  <= 1'b0;
            out_reg.level_index <= lvl_reg;
            out_reg.block_slot  <= cmd.slot;
            out_reg.center_x    <= cfp_pkg::sat32(dx[44:1]);
            out_reg.center_y    <= cfp_pkg::sat32(dy[44:1]);
            out_reg.width_x     <= bwx_reg;
            out_reg.width_y     <= bwy_reg;
            out_reg.block_count <= 6'd0;
            out_reg.last        <= 1'b0;
        end
        else if (cmd.int_emit)
        begin
            out_reg.piece_kind  <= 1'b1;
            out_reg.level_index <= lvl_reg;
            out_reg.block_slot  <= 4'd0;
            out_reg.center_x    <= cx_reg;
            out_reg.center_y    <= cy_reg;
            out_reg.width_x     <= lwx_reg;
            out_reg.width_y     <= lwy_reg;
            out_reg.block_count <= 6'(lvl_reg * 4'd12);
            out_reg.last        <= 1'b1;
        end
    end

    // 2*dist > 5*lwx
    assign status.stop     = (lvl_reg == nlev_reg - 3'd1)
                           || ({item_reg.view_distance, 1'b0} > 43'(lwx_reg * 43'd5));
    assign status.same     = (cx_reg == cache_x_reg[lvl_reg]) && (cy_reg == cache_y_reg[lvl_reg]);
    assign status.mod_done = done_x && done_y;
    assign out_item        = out_reg;
endmodule
`default_nettype wire

// File: design/cfp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_ctrl
// Sequencer for the level walk and result emission.
// ----------------------------------------------------------------------------
module cfp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire cfp_pkg::status_t status,
    output cfp_pkg::cmd_t        cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_MODST = 4'd2;
    localparam logic [3:0] S_MODW  = 4'd3;
    localparam logic [3:0] S_SNAP  = 4'd4;
    localparam logic [3:0] S_DEC   = 4'd5;
    localparam logic [3:0] S_RING  = 4'd6;
    localparam logic [3:0] S_RWAIT = 4'd7;
    localparam logic [3:0] S_IWAIT = 4'd8;
    localparam logic [3:0] S_MODW0 = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] slot_reg, slot_next;
    logic       ov_reg, ov_next;
    logic       fire;

    assign fire = ov_reg && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        ov_next    = fire ? 1'b0 : ov_reg;
        cmd        = '0;
        cmd.slot   = slot_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            S_SETUP:
            begin
                cmd.lvl_setup = 1'b1;
                state_next    = S_MODST;
            end
            S_MODST:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MODW0;
            end
            S_MODW0: state_next = S_MODW;
            S_MODW:
                if (status.mod_done)
                    state_next = S_SNAP;
            S_SNAP:
            begin
                cmd.snap   = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
                if (status.stop)
                begin
                    if (!ov_reg || fire)
                    begin
                        cmd.int_emit = 1'b1;
                        ov_next      = 1'b1;
                        state_next   = S_IWAIT;
                    end
                end
                else if (status.same)
                begin
                    cmd.next_lvl = 1'b1;
                    state_next   = S_SETUP;
                end
                else
                begin
                    cmd.cache_wr = 1'b1;
                    slot_next    = 4'd0;
                    state_next   = S_RING;
                end
            S_RING:
                if (!ov_reg || fire)
                begin
                    cmd.ring_emit = 1'b1;
                    ov_next       = 1'b1;
                    slot_next     = slot_reg + 4'd1;
                    if (slot_reg == 4'd11)
                        state_next = S_RWAIT;
                end
            S_RWAIT:
            begin
                cmd.next_lvl = 1'b1;
                state_next   = S_SETUP;
            end
            S_IWAIT:
                if (fire)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= 4'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

// File: design/clipmap_footprint_placer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clipmap_footprint_placer
// Places clipmap ring and interior blocks for one view update.
// ----------------------------------------------------------------------------
// in_valid/in_stall take a transaction of focus point and view distance.
// out_valid/out_stall deliver 1 to 49 result transactions per update; the
// interior block comes last and carries last = 1.
// Per level: setup, floor modulo (two 32-step serial dividers, one per
// axis, running side by side) and the stop/cache decision, then a ring
// when the snapped center moved. One update is processed at a time;
// in_stall stays high until the last result is taken.
// A stalled receiver holds the result register and the walk waits.
// Reset returns configuration to defaults and clears the center cache.
// Configuration writes (cfg_we, cfg_index, cfg_data) apply immediately and
// must be issued while no update is in flight.
// ----------------------------------------------------------------------------
module clipmap_footprint_placer (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire cfp_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cfp_pkg::out_item_t      out_data
);
    cfp_pkg::cmd_t    cmd;
    cfp_pkg::status_t status;

    cfp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
    );

    cfp_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_item(in_data), .cmd(cmd), .status(status),
        .out_item(out_data)
    );
endmodule
`default_nettype wire
